[rtl/lcg48_pkg.sv]
package lcg48_pkg;

    localparam int SEED_W = 48;
    localparam int MUL_W  = 35;
    localparam int CHUNK_W = 16;
    localparam int DRAW31_W = 31;

    localparam logic [MUL_W-1:0]  LCG_MUL = 35'h5DEECE66D;
    localparam logic [SEED_W-1:0] LCG_ADD = 48'hB;
    localparam logic [SEED_W-1:0] LCG_DEFAULT_SEED = 48'd5489;
    localparam logic [SEED_W-1:0] LCG_RESET_SEED =
        LCG_DEFAULT_SEED ^ {{(SEED_W-MUL_W){1'b0}}, LCG_MUL};

    // item modes (s_tuser)
    localparam logic [2:0] MODE_RESEED  = 3'd0;
    localparam logic [2:0] MODE_RAW     = 3'd1;
    localparam logic [2:0] MODE_BOUNDED = 3'd2;
    localparam logic [2:0] MODE_LONG    = 3'd3;
    localparam logic [2:0] MODE_DOUBLE  = 3'd4;

    // handshake pair between the sequencer and an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

[rtl/lcg48_mul.sv]
module lcg48_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lcg48_pkg::SEED_W-1:0]  seed_in,
    output lcg48_pkg::unit_status_t       status,
    output logic [lcg48_pkg::SEED_W-1:0]  seed_out
);
    import lcg48_pkg::*;

    // seed * LCG_MUL + LCG_ADD mod 2^48, one 16-bit slice of the seed per cycle
    logic [SEED_W-1:0]            src_reg;
    logic [SEED_W-1:0]            acc_reg;
    logic [1:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [CHUNK_W-1:0]           chunk;
    logic [CHUNK_W+MUL_W-1:0]     prod;
    logic [SEED_W-1:0]            part;

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    chunk = src_reg[15:0];
            2'd1:    chunk = src_reg[31:16];
            default: chunk = src_reg[47:32];
        endcase
        prod = chunk * LCG_MUL;
        part = prod[SEED_W-1:0] << {cnt_reg, 4'b0000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            src_reg <= seed_in;
            acc_reg <= LCG_ADD;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + part;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign seed_out    = acc_reg;

endmodule

[rtl/lcg48_mod.sv]
module lcg48_mod (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lcg48_pkg::DRAW31_W-1:0]  dividend,
    input  logic [lcg48_pkg::DRAW31_W-1:0]  divisor,
    output lcg48_pkg::unit_status_t         status,
    output logic [lcg48_pkg::DRAW31_W-1:0]  rem
);
    import lcg48_pkg::*;

    // restoring remainder, one dividend bit per cycle, MSB first
    logic [DRAW31_W-1:0] dvd_reg;
    logic [DRAW31_W-1:0] dsr_reg;
    logic [DRAW31_W-1:0] rem_reg;
    logic [4:0]          cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DRAW31_W:0]   trial;
    logic [DRAW31_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DRAW31_W-1]};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DRAW31_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DRAW31_W-2:0], 1'b0};
            if (!diff[DRAW31_W])
                rem_reg <= diff[DRAW31_W-1:0];
            else
                rem_reg <= trial[DRAW31_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign rem         = rem_reg;

endmodule

[rtl/lcg48_random_generator_core.sv]
// 48-bit linear congruential generator (seed' = seed * 0x5DEECE66D + 0xB mod 2^48).
// Input channel s_*: one beat is one request; s_tuser carries the mode (reseed,
// raw bits, bounded int, long, double fraction), s_tdata the operands.
// Output channel m_*: exactly one result beat per request; m_tdata is the
// 64-bit value, m_tuser flags a bounded request whose bound was zero or less.
// Each seed advance runs through the shared 16x35 multiplier as three partial
// products plus the hand-off. Reseed, bad bounds and unused modes need no advance;
// raw and power-of-two bounded draws take one advance, long and double two.
// Other bounds add a bit-serial remainder plus a rejection check, and each
// rejected draw repeats the advance and the remainder.
// One request is in flight at a time: s_tready is high only when idle, so the
// next beat is taken in the cycle after the result moves out.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls, the sequencer holds its following
// result until the output register frees up.
// Reset: the seed loads 5489 ^ 0x5DEECE66D, output valid clears.
module lcg48_random_generator_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // seed_value[63:0], bit_count[69:64], bound[101:70], pad
    input  logic [2:0]    s_tuser,   // mode[2:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // value[63:0]
    output logic          m_tuser    // bad_bound
);
    import lcg48_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DRAW = 3'd1;   // waiting on the multiplier
    localparam logic [2:0] S_MOD  = 3'd2;   // waiting on the remainder unit
    localparam logic [2:0] S_DONE = 3'd3;   // result ready for the output register

    logic [2:0]          state_reg, state_next;
    logic [SEED_W-1:0]   seed_reg, seed_next;
    logic [2:0]          mode_reg, mode_next;
    logic [5:0]          nbits_reg, nbits_next;
    logic [31:0]         bnd_reg, bnd_next;
    logic                first_reg, first_next;
    logic [31:0]         hi_reg, hi_next;
    logic [DRAW31_W-1:0] r_reg, r_next;
    logic [63:0]         value_reg, value_next;
    logic                bad_reg, bad_next;
    logic                m_valid_reg, m_valid_next;
    logic [63:0]         m_data_reg, m_data_next;
    logic                m_bad_reg, m_bad_next;

    // input unpacking
    logic [63:0] in_seed;
    logic [5:0]  in_nbits;
    logic [31:0] in_bound;

    // shared units
    logic                mul_start;
    unit_status_t        mul_status;
    logic [SEED_W-1:0]   mul_seed;
    logic                mod_start;
    unit_status_t        mod_status;
    logic [DRAW31_W-1:0] mod_rem;

    // draw helpers
    logic [31:0]         top32;
    logic [31:0]         raw_word;
    logic [DRAW31_W-1:0] draw31;
    logic                bnd_pow2;
    logic [62:0]         pow2_prod;
    logic [31:0]         wrap_sum;

    assign in_seed  = s_tdata[63:0];
    assign in_nbits = s_tdata[69:64];
    assign in_bound = s_tdata[101:70];

    assign top32     = mul_seed[47:16];
    assign draw31    = mul_seed[47:17];
    assign raw_word  = (nbits_reg == 6'd0) ? 32'd0 : (top32 >> (6'd32 - nbits_reg));
    assign bnd_pow2  = ((bnd_reg & (bnd_reg - 32'd1)) == 32'd0);
    assign pow2_prod = bnd_reg * draw31;
    assign wrap_sum  = {1'b0, r_reg} - {1'b0, mod_rem} + bnd_reg - 32'd1;

    lcg48_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .seed_in  (seed_next),
        .status   (mul_status),
        .seed_out (mul_seed)
    );

    lcg48_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (draw31),
        .divisor  (bnd_reg[DRAW31_W-1:0]),
        .status   (mod_status),
        .rem      (mod_rem)
    );

    always_comb
    begin
        state_next   = state_reg;
        seed_next    = seed_reg;
        mode_next    = mode_reg;
        nbits_next   = nbits_reg;
        bnd_next     = bnd_reg;
        first_next   = first_reg;
        hi_next      = hi_reg;
        r_next       = r_reg;
        value_next   = value_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_bad_next   = m_bad_reg;
        mul_start    = 1'b0;
        mod_start    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser;
                    nbits_next = (in_nbits > 6'd32) ? 6'd32 : in_nbits;
                    bnd_next   = in_bound;
                    first_next = 1'b1;
                    value_next = 64'd0;
                    bad_next   = 1'b0;
                    unique case (s_tuser)
                        MODE_RESEED:
                        begin
                            seed_next  = in_seed[SEED_W-1:0] ^
                                         {{(SEED_W-MUL_W){1'b0}}, LCG_MUL};
                            state_next = S_DONE;
                        end
                        MODE_RAW, MODE_LONG, MODE_DOUBLE:
                        begin
                            mul_start  = 1'b1;
                            state_next = S_DRAW;
                        end
                        MODE_BOUNDED:
                        begin
                            if (in_bound == 32'd0 || in_bound[31])
                            begin
                                bad_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mul_start  = 1'b1;
                                state_next = S_DRAW;
                            end
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            S_DRAW:
            begin
                if (mul_status.done)
                begin
                    seed_next = mul_seed;
                    unique case (mode_reg)
                        MODE_RAW:
                        begin
                            value_next = {{32{raw_word[31]}}, raw_word};
                            state_next = S_DONE;
                        end
                        MODE_BOUNDED:
                        begin
                            if (bnd_pow2)
                            begin
                                value_next = {32'd0, pow2_prod[62:31]};
                                state_next = S_DONE;
                            end
                            else
                            begin
                                r_next     = draw31;
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                            end
                        end
                        MODE_LONG:
                        begin
                            if (first_reg)
                            begin
                                hi_next    = top32;
                                first_next = 1'b0;
                                mul_start  = 1'b1;
                            end
                            else
                            begin
                                value_next = {hi_reg, 32'd0} + {{32{top32[31]}}, top32};
                                state_next = S_DONE;
                            end
                        end
                        MODE_DOUBLE:
                        begin
                            if (first_reg)
                            begin
                                hi_next    = {6'd0, mul_seed[47:22]};
                                first_next = 1'b0;
                                mul_start  = 1'b1;
                            end
                            else
                            begin
                                value_next = {11'd0, hi_reg[25:0], mul_seed[47:21]};
                                state_next = S_DONE;
                            end
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            S_MOD:
            begin
                if (mod_status.done)
                begin
                    if (wrap_sum[31])
                    begin
                        // rejected draw: advance again
                        mul_start  = 1'b1;
                        state_next = S_DRAW;
                    end
                    else
                    begin
                        value_next = {33'd0, mod_rem};
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = value_reg;
                    m_bad_next   = bad_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            seed_reg    <= LCG_RESET_SEED;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seed_reg    <= seed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        nbits_reg  <= nbits_next;
        bnd_reg    <= bnd_next;
        first_reg  <= first_next;
        hi_reg     <= hi_next;
        r_reg      <= r_next;
        value_reg  <= value_next;
        bad_reg    <= bad_next;
        m_data_reg <= m_data_next;
        m_bad_reg  <= m_bad_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_bad_reg;

    // multiplier results only arrive while the sequencer waits for them
    a_mul_done_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
        mul_status.done |-> (state_reg == S_DRAW))
        else $error("multiplier finished outside the draw state");

    // remainder stays below the bound
    a_mod_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mod_status.done |-> (state_reg == S_MOD) && ({1'b0, mod_rem} < bnd_reg))
        else $error("remainder out of range");

    // no unit is running while a new request can be taken
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mul_status.busy && !mod_status.busy)
        else $error("shared unit busy while idle");

    // a bad-bound result carries a zero value
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) && m_tuser |-> (m_tdata == 64'd0))
        else $error("bad bound result with nonzero value");

endmodule
